// ===== hdl/ssl_pkg.sv =====
// ----------------------------------------------------------------------------
// Segment split package
// Shared types and constants for the segment-against-line classifier.
// ----------------------------------------------------------------------------
package ssl_pkg;

   // Quotient magnitude bits produced by the cut-point divider.
   localparam int DIV_STEPS = 32;

   // Configuration register indexes.
   typedef enum logic [1:0] {
      CSR_SPLIT_A = 2'd0,
      CSR_SPLIT_B = 2'd1,
      CSR_SPLIT_C = 2'd2,
      CSR_EPSILON = 2'd3
   } csr_index_type;

   // Side tags of a result piece.
   typedef enum logic [1:0] {
      SIDE_IN   = 2'd0,
      SIDE_OUT  = 2'd1,
      SIDE_DISC = 2'd2
   } side_type;

   // Segment as it travels down the pipeline.
   typedef struct packed {
      logic signed [31:0] sx;
      logic signed [31:0] sy;
      logic signed [31:0] ex;
      logic signed [31:0] ey;
      logic signed [31:0] a;
      logic signed [31:0] b;
      logic signed [31:0] c;
      logic               lend;
   } seg_type;

   // Classification carried alongside the segment.
   typedef struct packed {
      logic     straddle;
      side_type side;
   } cls_type;

endpackage

// ===== hdl/segment_split_by_line.sv =====
// ----------------------------------------------------------------------------
// Segment split by line
// Classifies 2D segments against a configured line and cuts straddlers.
// ----------------------------------------------------------------------------
// A segment is taken every cycle the pipeline advances. The pipeline runs as a
// unit: three arithmetic stages (endpoint products, saturated distances,
// cut-point products), an operand register and a 32-stage one-bit-per-stage
// divider for the cut point, and an output register. A straddling segment
// holds the output register for two transactions, so a stream of straddlers
// stalls the pipeline while each second piece is taken; all other segments
// sustain one per cycle while rsp_ready stays high.
module segment_split_by_line (
   input  logic                clock,
   input  logic                reset,
   input  logic                csr_we,
   input  logic [1:0]          csr_index,
   input  logic [31:0]         csr_wdata,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic signed [31:0]  req_start_x,
   input  logic signed [31:0]  req_start_y,
   input  logic signed [31:0]  req_end_x,
   input  logic signed [31:0]  req_end_y,
   input  logic signed [31:0]  req_own_a,
   input  logic signed [31:0]  req_own_b,
   input  logic signed [31:0]  req_own_c,
   input  logic                req_list_end,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [1:0]          rsp_side,
   output logic signed [31:0]  rsp_piece_start_x,
   output logic signed [31:0]  rsp_piece_start_y,
   output logic signed [31:0]  rsp_piece_end_x,
   output logic signed [31:0]  rsp_piece_end_y,
   output logic signed [31:0]  rsp_piece_a,
   output logic signed [31:0]  rsp_piece_b,
   output logic signed [31:0]  rsp_piece_c,
   output logic                rsp_last,
   output logic                rsp_list_end_out
);

   localparam int DS = ssl_pkg::DIV_STEPS;

   logic signed [31:0] split_a_ff, split_b_ff, split_c_ff;
   logic [15:0]        epsilon_ff;
   logic               en;

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         split_a_ff <= 32'sd65536;
         split_b_ff <= '0;
         split_c_ff <= '0;
         epsilon_ff <= 16'd1;
      end else if (csr_we) begin
         unique case (ssl_pkg::csr_index_type'(csr_index))
            ssl_pkg::CSR_SPLIT_A: split_a_ff <= csr_wdata;
            ssl_pkg::CSR_SPLIT_B: split_b_ff <= csr_wdata;
            ssl_pkg::CSR_SPLIT_C: split_c_ff <= csr_wdata;
            ssl_pkg::CSR_EPSILON: epsilon_ff <= csr_wdata[15:0];
            default: ;
         endcase
      end
   end

   ssl_pkg::seg_type seg_in;
   assign seg_in = '{sx: req_start_x, sy: req_start_y, ex: req_end_x, ey: req_end_y,
                     a: req_own_a, b: req_own_b, c: req_own_c, lend: req_list_end};
   assign req_ready = en;

   // Stage 1: endpoint products.
   ssl_pkg::seg_type   s1_ff;
   logic               v1_ff;
   logic signed [63:0] pas_ff, pbs_ff, pae_ff, pbe_ff;
   always_ff @(posedge clock) begin
      if (reset) v1_ff <= 1'b0;
      else if (en) v1_ff <= req_valid;
   end
   always_ff @(posedge clock) begin
      if (en) begin
         s1_ff  <= seg_in;
         pas_ff <= split_a_ff * req_start_x;
         pbs_ff <= split_b_ff * req_start_y;
         pae_ff <= split_a_ff * req_end_x;
         pbe_ff <= split_b_ff * req_end_y;
      end
   end

   // Stage 2: floored sums, saturated to 32 bits.
   function automatic logic signed [31:0] sat_dist(logic signed [63:0] pa,
                                                   logic signed [63:0] pb,
                                                   logic signed [31:0] c);
      logic signed [49:0] sum;
      sum = 50'(pa >>> 16) + 50'(pb >>> 16) + 50'(c);
      if (sum > 50'sd2147483647)       return 32'sh7fffffff;
      else if (sum < -50'sd2147483648) return 32'sh80000000;
      else                             return sum[31:0];
   endfunction

   ssl_pkg::seg_type   s2_ff;
   logic               v2_ff;
   logic signed [31:0] ds_ff, de_ff;
   always_ff @(posedge clock) begin
      if (reset) v2_ff <= 1'b0;
      else if (en) v2_ff <= v1_ff;
   end
   always_ff @(posedge clock) begin
      if (en) begin
         s2_ff <= s1_ff;
         ds_ff <= sat_dist(pas_ff, pbs_ff, split_c_ff);
         de_ff <= sat_dist(pae_ff, pbe_ff, split_c_ff);
      end
   end

   // Stage 3: classify and form the cut-point products.
   logic signed [32:0] eps33, ds33, de33;
   logic               far_s, far_e, opp;
   ssl_pkg::cls_type   cls3;
   assign eps33 = signed'({17'b0, epsilon_ff});
   assign ds33  = 33'(ds_ff);
   assign de33  = 33'(de_ff);
   assign far_s = (ds33 > eps33) || (ds33 < -eps33);
   assign far_e = (de33 > eps33) || (de33 < -eps33);
   assign opp   = (ds_ff > 0 && de_ff < 0) || (ds_ff < 0 && de_ff > 0);
   always_comb begin
      cls3.straddle = opp && far_s && far_e;
      if (ds33 > eps33)       cls3.side = ssl_pkg::SIDE_IN;
      else if (ds33 < -eps33) cls3.side = ssl_pkg::SIDE_OUT;
      else if (de33 > eps33)  cls3.side = ssl_pkg::SIDE_IN;
      else if (de33 < -eps33) cls3.side = ssl_pkg::SIDE_OUT;
      else                    cls3.side = ssl_pkg::SIDE_DISC;
   end

   ssl_pkg::seg_type   s3_ff;
   ssl_pkg::cls_type   c3_ff;
   logic               v3_ff;
   logic signed [63:0] pxs_ff, pxe_ff, pys_ff, pye_ff;
   logic signed [32:0] den_ff;
   always_ff @(posedge clock) begin
      if (reset) v3_ff <= 1'b0;
      else if (en) v3_ff <= v2_ff;
   end
   always_ff @(posedge clock) begin
      if (en) begin
         s3_ff  <= s2_ff;
         c3_ff  <= cls3;
         pxs_ff <= s2_ff.sx * de_ff;
         pxe_ff <= s2_ff.ex * ds_ff;
         pys_ff <= s2_ff.sy * de_ff;
         pye_ff <= s2_ff.ey * ds_ff;
         den_ff <= de33 - ds33;
      end
   end

   // Numerators and divisor as magnitude and sign for the dividers.
   logic signed [64:0] numx, numy, nxm, nym;
   logic signed [32:0] denm;
   assign numx = 65'(pxs_ff) - 65'(pxe_ff);
   assign numy = 65'(pys_ff) - 65'(pye_ff);
   assign nxm  = numx[64] ? -numx : numx;
   assign nym  = numy[64] ? -numy : numy;
   assign denm = den_ff[32] ? -den_ff : den_ff;

   logic signed [31:0] cut_x, cut_y;
   ssl_div u_div_x (.clock(clock), .en(en), .num_mag(nxm[63:0]),
                    .neg(numx[64] ^ den_ff[32]), .den_mag(denm), .quot(cut_x));
   ssl_div u_div_y (.clock(clock), .en(en), .num_mag(nym[63:0]),
                    .neg(numy[64] ^ den_ff[32]), .den_mag(denm), .quot(cut_y));

   // Segment and class travel beside the divider stages.
   ssl_pkg::seg_type pseg_ff [0:DS];
   ssl_pkg::cls_type pcls_ff [0:DS];
   logic [DS:0]      pv_ff;
   always_ff @(posedge clock) begin
      if (reset) pv_ff <= '0;
      else if (en) pv_ff <= {pv_ff[DS-1:0], v3_ff};
   end
   always_ff @(posedge clock) begin
      if (en) begin
         pseg_ff[0] <= s3_ff;
         pcls_ff[0] <= c3_ff;
         for (int i = 1; i <= DS; i++) begin
            pseg_ff[i] <= pseg_ff[i-1];
            pcls_ff[i] <= pcls_ff[i-1];
         end
      end
   end

   // Output register; a straddler gives two transactions from it.
   ssl_pkg::seg_type   oseg_ff;
   ssl_pkg::cls_type   ocls_ff;
   logic signed [31:0] ocx_ff, ocy_ff;
   logic               ov_ff, phase_ff, fire, done;
   assign fire = ov_ff && rsp_ready;
   assign done = fire && (!ocls_ff.straddle || phase_ff);
   assign en   = !ov_ff || done;
   always_ff @(posedge clock) begin
      if (reset) begin
         ov_ff    <= 1'b0;
         phase_ff <= 1'b0;
      end else if (en) begin
         ov_ff    <= pv_ff[DS];
         phase_ff <= 1'b0;
      end else if (fire) begin
         phase_ff <= 1'b1;
      end
   end
   always_ff @(posedge clock) begin
      if (en) begin
         oseg_ff <= pseg_ff[DS];
         ocls_ff <= pcls_ff[DS];
         ocx_ff  <= cut_x;
         ocy_ff  <= cut_y;
      end
   end

   // Result fields for the piece on show.
   always_comb begin
      rsp_valid   = ov_ff;
      rsp_piece_a = oseg_ff.a;
      rsp_piece_b = oseg_ff.b;
      rsp_piece_c = oseg_ff.c;
      if (ocls_ff.straddle && !phase_ff) begin
         rsp_side          = ocls_ff.side;
         rsp_piece_start_x = oseg_ff.sx;
         rsp_piece_start_y = oseg_ff.sy;
         rsp_piece_end_x   = ocx_ff;
         rsp_piece_end_y   = ocy_ff;
         rsp_last          = 1'b0;
         rsp_list_end_out  = 1'b0;
      end else if (ocls_ff.straddle) begin
         rsp_side          = ocls_ff.side ^ 2'd1;
         rsp_piece_start_x = ocx_ff;
         rsp_piece_start_y = ocy_ff;
         rsp_piece_end_x   = oseg_ff.ex;
         rsp_piece_end_y   = oseg_ff.ey;
         rsp_last          = 1'b1;
         rsp_list_end_out  = oseg_ff.lend;
      end else begin
         rsp_side          = ocls_ff.side;
         rsp_piece_start_x = oseg_ff.sx;
         rsp_piece_start_y = oseg_ff.sy;
         rsp_piece_end_x   = oseg_ff.ex;
         rsp_piece_end_y   = oseg_ff.ey;
         rsp_last          = 1'b1;
         rsp_list_end_out  = oseg_ff.lend;
      end
   end

`ifndef NO_ASSERTIONS
   // The second piece only exists for a straddling segment on show.
   a_phase_straddle: assert property (@(posedge clock) disable iff (reset)
      phase_ff |-> (ov_ff && ocls_ff.straddle))
      else $error("second piece without a straddling segment");

   // An accepted transaction enters the first stage.
   a_accept_enters: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> v1_ff)
      else $error("accepted segment lost at stage one");

   // While stalled the divider tail keeps its valid bit.
   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      !en |=> $stable(pv_ff[DS]))
      else $error("pipeline moved during a stall");

   // A straddler never leaves before both pieces are taken.
   a_two_pieces: assert property (@(posedge clock) disable iff (reset)
      (fire && ocls_ff.straddle && !phase_ff) |=> (ov_ff && phase_ff))
      else $error("straddling segment dropped after first piece");
`endif

endmodule

// ===== hdl/ssl_div.sv =====
// ----------------------------------------------------------------------------
// Cut-point divider
// Pipelined restoring divider, one quotient bit per stage, sign applied last.
// ----------------------------------------------------------------------------
module ssl_div (
   input  logic                             clock,
   input  logic                             en,
   input  logic [63:0]                      num_mag,
   input  logic                             neg,
   input  logic [32:0]                      den_mag,
   output logic signed [31:0]               quot
);

   logic [63:0]                    rem_ff [0:ssl_pkg::DIV_STEPS];
   logic [32:0]                    den_ff [0:ssl_pkg::DIV_STEPS];
   logic [ssl_pkg::DIV_STEPS-1:0]  q_ff   [0:ssl_pkg::DIV_STEPS];
   logic                           neg_ff [0:ssl_pkg::DIV_STEPS];

   // Capture the operands.
   always_ff @(posedge clock) begin
      if (en) begin
         rem_ff[0] <= num_mag;
         den_ff[0] <= den_mag;
         q_ff[0]   <= '0;
         neg_ff[0] <= neg;
      end
   end

   // One quotient bit per stage, most significant first.
   for (genvar i = 1; i <= ssl_pkg::DIV_STEPS; i++) begin : g_step
      logic [64:0] dsh;
      logic [64:0] diff;
      assign dsh  = {32'b0, den_ff[i-1]} << (ssl_pkg::DIV_STEPS - i);
      assign diff = {1'b0, rem_ff[i-1]} - dsh;
      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[i] <= diff[64] ? rem_ff[i-1] : diff[63:0];
            q_ff[i]   <= {q_ff[i-1][ssl_pkg::DIV_STEPS-2:0], ~diff[64]};
            den_ff[i] <= den_ff[i-1];
            neg_ff[i] <= neg_ff[i-1];
         end
      end
   end

   // Truncation toward zero: negate the magnitude when the signs differ.
   assign quot = neg_ff[ssl_pkg::DIV_STEPS] ? -signed'(q_ff[ssl_pkg::DIV_STEPS])
                                            : signed'(q_ff[ssl_pkg::DIV_STEPS]);

endmodule
